@@ hdl/btf_pkg.sv @@
// Package for the background tile fetcher: payload structs, fetch phases,
// register indexes and address constants. It depends on nothing else.
package btf_pkg;

  localparam logic [15:0] MAP_BASE_LOW_DEF       = 16'd38912;
  localparam logic [15:0] MAP_BASE_HIGH_DEF      = 16'd39936;
  localparam logic [15:0] DATA_BASE_UNSIGNED_DEF = 16'd32768;
  localparam logic [15:0] DATA_BASE_SIGNED_DEF   = 16'd36864;

  // The map is 32 tiles wide, so a column is five bits.
  localparam int unsigned MAP_WIDTH = 32;
  localparam int unsigned COL_W     = $clog2(MAP_WIDTH);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAP_WIDTH - 1);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_VSCROLL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_SELECT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_MODE  = 2'd2;

  localparam logic CMD_NEW_LINE = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  typedef enum logic [2:0] {
    PH_MAP  = 3'd0,
    PH_ID   = 3'd1,
    PH_LOW  = 3'd2,
    PH_HIGH = 3'd3,
    PH_PUSH = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  typedef struct packed {
    logic       command;
    logic [7:0] scanline;
    logic [7:0] mem_data;
    logic       fifo_has_room;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_addr;
    logic        read_valid;
    logic        push_valid;
    logic [15:0] pixels;
    logic        line_done;
  } out_item_t;

endpackage

@@ hdl/btf_stage.sv @@
// Register slice for one channel: holds one transfer and passes stall back.
// Generic over the payload width; it uses no package.
module btf_stage #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_stall,
  input  logic [W-1:0] up_data,
  output logic         dn_valid,
  input  logic         dn_stall,
  output logic [W-1:0] dn_data
);

  logic         valid_r;
  logic [W-1:0] data_r;
  logic         load;

  assign up_stall = valid_r && dn_stall;
  assign load     = !up_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      data_r <= up_data;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

@@ hdl/btf_fetch.sv @@
// Fetch engine: phase sequencer, tile state, configuration registers and the
// address and pixel logic for one item. Depends on btf_pkg.
module btf_fetch #(
  parameter logic [15:0] MAP_BASE_LOW       = btf_pkg::MAP_BASE_LOW_DEF,
  parameter logic [15:0] MAP_BASE_HIGH      = btf_pkg::MAP_BASE_HIGH_DEF,
  parameter logic [15:0] DATA_BASE_UNSIGNED = btf_pkg::DATA_BASE_UNSIGNED_DEF,
  parameter logic [15:0] DATA_BASE_SIGNED   = btf_pkg::DATA_BASE_SIGNED_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [btf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [btf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                fire,
  input  btf_pkg::in_item_t                   item,
  output btf_pkg::out_item_t                  result
);

  logic [7:0]                   vscroll_r;
  logic                         map_select_r;
  logic                         data_mode_r;

  btf_pkg::phase_t              phase_r, phase_nxt;
  logic [btf_pkg::COL_W-1:0]    column_r, column_nxt;
  logic [7:0]                   line_r, line_nxt;
  logic [15:0]                  tile_addr_r, tile_addr_nxt;
  logic [7:0]                   low_r, low_nxt;
  logic [7:0]                   high_r, high_nxt;

  logic [7:0]                   shifted;
  logic [15:0]                  map_addr;
  logic [15:0]                  row_addr;
  logic [15:0]                  pix;
  logic                         tick;
  logic                         last_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vscroll_r    <= '0;
      map_select_r <= 1'b0;
      data_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        btf_pkg::CFG_VSCROLL:    vscroll_r    <= cfg_wdata;
        btf_pkg::CFG_MAP_SELECT: map_select_r <= cfg_wdata[0];
        btf_pkg::CFG_DATA_MODE:  data_mode_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign tick     = (item.command == btf_pkg::CMD_TICK);
  assign last_col = (column_r == btf_pkg::LAST_COL);
  assign shifted  = line_r + vscroll_r;

  always_comb begin
    logic [15:0] base;
    base     = map_select_r ? MAP_BASE_HIGH : MAP_BASE_LOW;
    map_addr = base + {6'd0, shifted[7:3], 5'd0} + {11'd0, column_r};
  end

  always_comb begin
    logic [15:0] data_base;
    logic [15:0] id_off;
    if (data_mode_r) begin
      data_base = DATA_BASE_UNSIGNED;
      id_off    = {4'd0, item.mem_data, 4'd0};
    end else begin
      data_base = DATA_BASE_SIGNED;
      id_off    = {{4{item.mem_data[7]}}, item.mem_data, 4'd0};
    end
    row_addr = data_base + id_off + {12'd0, shifted[2:0], 1'b0};
  end

  always_comb begin
    for (int x = 0; x < 8; x++) begin
      pix[15 - 2*x -: 2] = {high_r[7 - x], low_r[7 - x]};
    end
  end

  // Next state.
  always_comb begin
    phase_nxt     = phase_r;
    column_nxt    = column_r;
    line_nxt      = line_r;
    tile_addr_nxt = tile_addr_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    if (!tick) begin
      line_nxt   = item.scanline;
      column_nxt = '0;
      phase_nxt  = btf_pkg::PH_MAP;
    end else begin
      case (phase_r)
        btf_pkg::PH_MAP:  phase_nxt = btf_pkg::PH_ID;
        btf_pkg::PH_ID: begin
          tile_addr_nxt = row_addr;
          phase_nxt     = btf_pkg::PH_LOW;
        end
        btf_pkg::PH_LOW: begin
          low_nxt   = item.mem_data;
          phase_nxt = btf_pkg::PH_HIGH;
        end
        btf_pkg::PH_HIGH: begin
          high_nxt  = item.mem_data;
          phase_nxt = btf_pkg::PH_PUSH;
        end
        btf_pkg::PH_PUSH: begin
          if (item.fifo_has_room) begin
            if (last_col) begin
              column_nxt = '0;
              phase_nxt  = btf_pkg::PH_DONE;
            end else begin
              column_nxt = column_r + 1'b1;
              phase_nxt  = btf_pkg::PH_MAP;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result of this item.
  always_comb begin
    result = '0;
    if (tick) begin
      case (phase_r)
        btf_pkg::PH_MAP: begin
          result.read_addr  = map_addr;
          result.read_valid = 1'b1;
        end
        btf_pkg::PH_ID: begin
          result.read_addr  = row_addr;
          result.read_valid = 1'b1;
        end
        btf_pkg::PH_LOW: begin
          result.read_addr  = tile_addr_r + 16'd1;
          result.read_valid = 1'b1;
        end
        btf_pkg::PH_PUSH: begin
          if (item.fifo_has_room) begin
            result.push_valid = 1'b1;
            result.pixels     = pix;
            result.line_done  = last_col;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= btf_pkg::PH_DONE;
      column_r <= '0;
      line_r   <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      column_r <= column_nxt;
      line_r   <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_addr_r <= '0;
      low_r       <= '0;
      high_r      <= '0;
    end else if (fire) begin
      tile_addr_r <= tile_addr_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
    end
  end

  a_push_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    result.push_valid |-> !result.read_valid)
    else $error("push and read request in the same item");

  a_done_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    result.line_done |-> result.push_valid && column_r == btf_pkg::LAST_COL)
    else $error("line_done without a push of the last column");

  a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && result.line_done) |=> phase_r == btf_pkg::PH_DONE && column_r == '0)
    else $error("fetcher did not idle after the last tile");

  a_new_line: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.command == btf_pkg::CMD_NEW_LINE) |=> phase_r == btf_pkg::PH_MAP)
    else $error("new line did not restart the map phase");

endmodule

@@ hdl/background_tile_fetcher.sv @@
// Top level of the background tile fetcher: input slice, fetch engine and
// result slice. Depends on btf_pkg, btf_stage and btf_fetch.
//
//   channel   ports                               direction
//   input     in_valid, in_stall, in_item         item in, one per transfer
//   result    out_valid, out_stall, out_item      one result per input item
//   config    cfg_we, cfg_index, cfg_wdata        register write, no wait
//
// An item is held in the input register and its result is then loaded into the
// result register, so the result transfer follows the input transfer through
// both registers; one item is taken every cycle while the result side is free.
// The fetch state advances as an item moves from the input register into the
// result register. Reset idles the fetcher until a new-line item arrives.
// A stall on the result side holds the result register and, while it holds an
// item, the input register too; an empty input register still takes one transfer.
module background_tile_fetcher #(
  parameter logic [15:0] MAP_BASE_LOW       = btf_pkg::MAP_BASE_LOW_DEF,
  parameter logic [15:0] MAP_BASE_HIGH      = btf_pkg::MAP_BASE_HIGH_DEF,
  parameter logic [15:0] DATA_BASE_UNSIGNED = btf_pkg::DATA_BASE_UNSIGNED_DEF,
  parameter logic [15:0] DATA_BASE_SIGNED   = btf_pkg::DATA_BASE_SIGNED_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  btf_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output btf_pkg::out_item_t              out_item,
  input  logic                            cfg_we,
  input  logic [btf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [btf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned IN_W  = $bits(btf_pkg::in_item_t);
  localparam int unsigned OUT_W = $bits(btf_pkg::out_item_t);

  logic               mid_valid;
  logic               mid_stall;
  logic [IN_W-1:0]    mid_bits;
  btf_pkg::in_item_t  mid_item;
  btf_pkg::out_item_t result;
  logic [OUT_W-1:0]   out_bits;
  logic               fire;

  btf_stage #(.W(IN_W)) u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_data  (in_item),
    .dn_valid (mid_valid),
    .dn_stall (mid_stall),
    .dn_data  (mid_bits)
  );

  assign mid_item = btf_pkg::in_item_t'(mid_bits);
  assign fire     = mid_valid && !mid_stall;

  btf_fetch #(
    .MAP_BASE_LOW       (MAP_BASE_LOW),
    .MAP_BASE_HIGH      (MAP_BASE_HIGH),
    .DATA_BASE_UNSIGNED (DATA_BASE_UNSIGNED),
    .DATA_BASE_SIGNED   (DATA_BASE_SIGNED)
  ) u_fetch (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (mid_item),
    .result    (result)
  );

  btf_stage #(.W(OUT_W)) u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mid_valid),
    .up_stall (mid_stall),
    .up_data  (result),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_data  (out_bits)
  );

  assign out_item = btf_pkg::out_item_t'(out_bits);

endmodule
